// ===== rtl/wkbp_pkg.sv =====
// ----------------------------------------------------------------------------
// wkbp_pkg
// Shared types, codes and arithmetic helpers for the WKB polygon ring parser.
// ----------------------------------------------------------------------------
package wkbp_pkg;

    // Field widths
    localparam int LEN_FIELD_W = 32;
    localparam int WORD_W      = 32;
    localparam int STRIDE_W    = 6;
    localparam int NEED_W      = WORD_W + STRIDE_W;   // 13 + count * stride never wraps

    // Header layout (byte positions)
    localparam logic [3:0] HDR_BYTES   = 4'd13;
    localparam logic [3:0] COUNT_START = 4'd9;
    localparam logic [3:0] TYPE_END    = 4'd4;
    localparam logic [3:0] RINGS_END   = COUNT_START - 4'd1;

    // Geometry type word: code = dim * 1000 + 3
    localparam int DIM_DIVISOR = 1000;
    localparam int POLY_CODE   = 3;
    localparam int ODD_DIV     = DIM_DIVISOR / 8;      // 125
    localparam int FOLD_K      = 128 - ODD_DIV;        // 128 mod 125
    localparam logic [WORD_W-1:0] TYPE_Z  = WORD_W'(DIM_DIVISOR * 1 + POLY_CODE);
    localparam logic [WORD_W-1:0] TYPE_M  = WORD_W'(DIM_DIVISOR * 2 + POLY_CODE);
    localparam logic [WORD_W-1:0] TYPE_ZM = WORD_W'(DIM_DIVISOR * 3 + POLY_CODE);

    // Point sizes in bytes
    localparam logic [STRIDE_W-1:0] STRIDE_BASE = 6'd16;
    localparam logic [STRIDE_W-1:0] STRIDE_ONE  = 6'd24;
    localparam logic [STRIDE_W-1:0] STRIDE_TWO  = 6'd32;

    // 256^n mod 125, n = 0..3
    localparam logic [6:0] BYTE_WEIGHT [0:3] = '{7'd1, 7'd6, 7'd36, 7'd91};

    typedef enum logic [2:0] {
        ST_POINT   = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_SHORT   = 3'd2,
        ST_ORDER   = 3'd3,
        ST_NOTPOLY = 3'd4,
        ST_NORINGS = 3'd5,
        ST_OVERRUN = 3'd6
    } t_status;

    typedef struct packed {
        t_status      status;
        logic [63:0]  lng;
        logic [63:0]  lat;
        logic [31:0]  num;
        logic         fin;
    } t_result;

    // x mod 125 by folding on 128 = 3 (mod 125)
    function automatic logic [6:0] mod_fold(input logic [15:0] x);
        logic [10:0] y1;
        logic [7:0]  y2;
        y1 = 11'(x[15:7]) * 11'(FOLD_K) + 11'(x[6:0]);
        y2 = 8'(y1[10:7]) * 8'(FOLD_K) + 8'(y1[6:0]);
        return (y2 >= 8'(ODD_DIV)) ? 7'(y2 - 8'(ODD_DIV)) : 7'(y2);
    endfunction

endpackage

// ===== rtl/wkb_polygon_ring_parser_unit.sv =====
// ----------------------------------------------------------------------------
// wkb_polygon_ring_parser_unit
// Byte-serial WKB polygon parser: emits the first ring's points or a status.
// ----------------------------------------------------------------------------
// Usage
//   Slave side takes one message byte per transaction, with the message's
//   total length alongside (held constant over the message) and tlast on the
//   final byte. Master side gives at most one result per byte: a point
//   (raw little-endian IEEE-754 longitude/latitude, point index), an empty
//   ring status, or an error status; tlast marks the final result.
//   After a final result the rest of the message is swallowed until tlast.
// Timing
//   One byte per cycle sustained unless a result finds the output full. A byte
//   is registered on acceptance, runs through the parse step from the input
//   register and any result is loaded into the output register as the parser advances.
//   The critical path is the point-count check at the end of the header
//   (count times point size, plus 13, compared with the length).
// Stall
//   Bytes that give no result keep flowing while a result waits; a byte that
//   gives a result waits in the input register until the output frees up.
// Reset
//   Synchronous, active low. Parser returns to the start of a message, both
//   pipeline registers empty. No clearing pass; ready in the next cycle.
// ----------------------------------------------------------------------------
module wkb_polygon_ring_parser_unit import wkbp_pkg::*; #(
    parameter int LENGTH_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [39:0]  i_s_axis_tdata,   // [7:0] data_byte, [39:8] message_length
    input  logic         i_s_axis_tlast,   // last_byte
    // master side
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [159:0] o_m_axis_tdata,   // [63:0] longitude_bits, [127:64] latitude_bits,
                                           // [159:128] point_number
    output logic [2:0]   o_m_axis_tuser,   // status
    output logic         o_m_axis_tlast    // final_result
);

    // only the low LENGTH_WIDTH bits of the 32-bit length take part
    localparam int LEN_BITS = (LENGTH_WIDTH < LEN_FIELD_W) ? LENGTH_WIDTH : LEN_FIELD_W;

    logic                w_in_vld;
    logic [7:0]          w_byte;
    logic [LEN_BITS-1:0] w_len;
    logic                w_last;
    logic                w_res_vld;
    t_result             w_res;
    t_result             w_out;
    logic                w_adv;

    // advance the parser unless this byte makes a result that has nowhere to go
    assign w_adv = w_in_vld && (!w_res_vld || !o_m_axis_tvalid || i_m_axis_tready);

    wkbp_in_stage #(
        .LEN_BITS (LEN_BITS)
    ) u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata[7:0]),
        .i_len   (i_s_axis_tdata[39:8]),
        .i_last  (i_s_axis_tlast),
        .i_adv   (w_adv),
        .o_vld   (w_in_vld),
        .o_byte  (w_byte),
        .o_len   (w_len),
        .o_last  (w_last)
    );

    wkbp_parse #(
        .LEN_BITS (LEN_BITS)
    ) u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (w_adv),
        .i_byte    (w_byte),
        .i_len     (w_len),
        .i_last    (w_last),
        .o_res_vld (w_res_vld),
        .o_res     (w_res)
    );

    wkbp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_adv && w_res_vld),
        .i_res   (w_res),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_res   (w_out)
    );

    assign o_m_axis_tdata = {w_out.num, w_out.lat, w_out.lng};
    assign o_m_axis_tuser = w_out.status;
    assign o_m_axis_tlast = w_out.fin;

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------

    // a result made by the parser shows up next cycle with its status
    a_res_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && w_res_vld |=> o_m_axis_tvalid && (o_m_axis_tuser == $past(w_res.status)))
        else $error("parser result not registered");

    // statuses other than a point always close the message
    a_status_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != ST_POINT) |-> o_m_axis_tlast)
        else $error("status result without final flag");

    // statuses other than a point carry no coordinates
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != ST_POINT) |-> (o_m_axis_tdata == '0))
        else $error("status result with data");

    // a pending result must not be overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_vld && w_res_vld && o_m_axis_tvalid && !i_m_axis_tready |-> !w_adv)
        else $error("result register overwritten");

endmodule

// ===== rtl/wkbp_in_stage.sv =====
// ----------------------------------------------------------------------------
// wkbp_in_stage
// Input register: holds one accepted byte with its length and end flag.
// ----------------------------------------------------------------------------
module wkbp_in_stage import wkbp_pkg::*; #(
    parameter int LEN_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_byte,
    input  logic [LEN_FIELD_W-1:0] i_len,
    input  logic                   i_last,
    input  logic                   i_adv,
    output logic                   o_vld,
    output logic [7:0]             o_byte,
    output logic [LEN_BITS-1:0]    o_len,
    output logic                   o_last
);

    logic                r_vld;
    logic [7:0]          r_byte;
    logic [LEN_BITS-1:0] r_len;
    logic                r_last;
    logic                w_load;

    assign o_ready = !r_vld || i_adv;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_load) begin
            r_vld <= 1'b1;
        end else if (i_adv) begin
            r_vld <= 1'b0;
        end
        if (w_load) begin
            r_byte <= i_byte;
            r_len  <= i_len[LEN_BITS-1:0];
            r_last <= i_last;
        end
    end

    assign o_vld  = r_vld;
    assign o_byte = r_byte;
    assign o_len  = r_len;
    assign o_last = r_last;

endmodule

// ===== rtl/wkbp_parse.sv =====
// ----------------------------------------------------------------------------
// wkbp_parse
// Parser state and the per-byte step: header checks, point gathering.
// ----------------------------------------------------------------------------
module wkbp_parse import wkbp_pkg::*; #(
    parameter int LEN_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic [7:0]          i_byte,
    input  logic [LEN_BITS-1:0] i_len,
    input  logic                i_last,
    output logic                o_res_vld,
    output t_result             o_res
);

    logic [3:0]          r_pos,      n_pos;
    logic                r_little,   n_little;
    logic [WORD_W-1:0]   r_word,     n_word;
    logic [6:0]          r_mod,      n_mod;
    logic [STRIDE_W-1:0] r_stride,   n_stride;
    logic [31:0]         r_expected, n_expected;
    logic [31:0]         r_done,     n_done;
    logic [4:0]          r_bip,      n_bip;
    logic [63:0]         r_lng,      n_lng;
    logic [63:0]         r_lat,      n_lat;
    logic                r_finished, n_finished;

    logic [NEED_W-1:0]   w_len;
    logic [1:0]          w_k;
    logic [1:0]          w_widx;
    logic [WORD_W-1:0]   w_word_base;
    logic [WORD_W-1:0]   w_word_new;
    logic [6:0]          w_mod_base;
    logic [6:0]          w_mod_new;
    logic [NEED_W-1:0]   w_need;
    logic                w_is_poly;
    logic [63:0]         w_lng_new;
    logic [63:0]         w_lat_new;
    logic [STRIDE_W-1:0] w_bip_inc;
    logic [31:0]         w_done_inc;

    // header word gather, type residue mod 125 kept alongside
    assign w_len       = NEED_W'(i_len);
    assign w_k         = 2'(r_pos - 4'd1);
    assign w_widx      = r_little ? w_k : ~w_k;
    assign w_word_base = (w_k == 2'd0) ? '0 : r_word;
    assign w_mod_base  = (w_k == 2'd0) ? '0 : r_mod;
    assign w_word_new  = r_little ? (w_word_base | (WORD_W'(i_byte) << {w_k, 3'b000}))
                                  : {w_word_base[WORD_W-9:0], i_byte};
    assign w_mod_new   = mod_fold(16'(w_mod_base) + 16'(i_byte) * 16'(BYTE_WEIGHT[w_widx]));
    assign w_is_poly   = (w_word_new[2:0] == 3'(POLY_CODE)) && (w_mod_new == 7'(POLY_CODE));
    assign w_need      = NEED_W'(HDR_BYTES) + NEED_W'(w_word_new) * NEED_W'(r_stride);

    // point gather
    assign w_lng_new   = r_little ? (r_lng | (64'(i_byte) << {r_bip[2:0], 3'b000}))
                                  : {r_lng[55:0], i_byte};
    assign w_lat_new   = r_little ? (r_lat | (64'(i_byte) << {r_bip[2:0], 3'b000}))
                                  : {r_lat[55:0], i_byte};
    assign w_bip_inc   = STRIDE_W'(r_bip) + 6'd1;
    assign w_done_inc  = r_done + 32'd1;

    always_comb begin
        n_pos      = r_pos;
        n_little   = r_little;
        n_word     = r_word;
        n_mod      = r_mod;
        n_stride   = r_stride;
        n_expected = r_expected;
        n_done     = r_done;
        n_bip      = r_bip;
        n_lng      = r_lng;
        n_lat      = r_lat;
        n_finished = r_finished;
        o_res_vld  = 1'b0;
        o_res      = '{status: ST_POINT, lng: '0, lat: '0, num: '0, fin: 1'b1};

        if (!r_finished) begin
            if (r_pos < HDR_BYTES) begin
                n_pos = r_pos + 4'd1;
                if (r_pos == 4'd0) begin
                    if (w_len < NEED_W'(HDR_BYTES)) begin
                        n_finished   = 1'b1;
                        o_res_vld    = 1'b1;
                        o_res.status = ST_SHORT;
                    end else if (i_byte > 8'd1) begin
                        n_finished   = 1'b1;
                        o_res_vld    = 1'b1;
                        o_res.status = ST_ORDER;
                    end else begin
                        n_little = i_byte[0];
                    end
                end else begin
                    n_word = w_word_new;
                    n_mod  = w_mod_new;
                    if (w_k == 2'd3) begin
                        if (r_pos == TYPE_END) begin
                            if (!w_is_poly) begin
                                n_finished   = 1'b1;
                                o_res_vld    = 1'b1;
                                o_res.status = ST_NOTPOLY;
                            end else if (w_word_new == TYPE_Z || w_word_new == TYPE_M) begin
                                n_stride = STRIDE_ONE;
                            end else if (w_word_new == TYPE_ZM) begin
                                n_stride = STRIDE_TWO;
                            end else begin
                                n_stride = STRIDE_BASE;
                            end
                        end else if (r_pos == RINGS_END) begin
                            if (w_word_new == '0) begin
                                n_finished   = 1'b1;
                                o_res_vld    = 1'b1;
                                o_res.status = ST_NORINGS;
                            end
                        end else begin
                            if (w_need > w_len) begin
                                n_finished   = 1'b1;
                                o_res_vld    = 1'b1;
                                o_res.status = ST_OVERRUN;
                            end else if (w_word_new == '0) begin
                                n_finished   = 1'b1;
                                o_res_vld    = 1'b1;
                                o_res.status = ST_EMPTY;
                            end else begin
                                n_expected = w_word_new;
                                n_done     = '0;
                                n_bip      = '0;
                                n_lng      = '0;
                                n_lat      = '0;
                            end
                        end
                    end
                end
            end else begin
                if (r_bip < 5'd8) begin
                    n_lng = w_lng_new;
                end else if (r_bip < 5'd16) begin
                    n_lat = w_lat_new;
                end
                if (w_bip_inc >= r_stride) begin
                    o_res_vld    = 1'b1;
                    o_res.status = ST_POINT;
                    o_res.lng    = n_lng;
                    o_res.lat    = n_lat;
                    o_res.num    = r_done;
                    o_res.fin    = (w_done_inc == r_expected);
                    n_done       = w_done_inc;
                    n_bip        = '0;
                    n_lng        = '0;
                    n_lat        = '0;
                    n_finished   = (w_done_inc == r_expected);
                end else begin
                    n_bip = 5'(w_bip_inc);
                end
            end
        end

        // end of message: back to start
        if (i_last) begin
            n_pos      = '0;
            n_little   = 1'b0;
            n_word     = '0;
            n_mod      = '0;
            n_stride   = STRIDE_BASE;
            n_expected = '0;
            n_done     = '0;
            n_bip      = '0;
            n_lng      = '0;
            n_lat      = '0;
            n_finished = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_little   <= 1'b0;
            r_word     <= '0;
            r_mod      <= '0;
            r_stride   <= STRIDE_BASE;
            r_expected <= '0;
            r_done     <= '0;
            r_bip      <= '0;
            r_lng      <= '0;
            r_lat      <= '0;
            r_finished <= 1'b0;
        end else if (i_go) begin
            r_pos      <= n_pos;
            r_little   <= n_little;
            r_word     <= n_word;
            r_mod      <= n_mod;
            r_stride   <= n_stride;
            r_expected <= n_expected;
            r_done     <= n_done;
            r_bip      <= n_bip;
            r_lng      <= n_lng;
            r_lat      <= n_lat;
            r_finished <= n_finished;
        end
    end

endmodule

// ===== rtl/wkbp_out_stage.sv =====
// ----------------------------------------------------------------------------
// wkbp_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module wkbp_out_stage import wkbp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_vld;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_vld;
    assign o_res   = r_res;

endmodule

// ===== tb/sv/wkbp_ring_checker.sv =====
// ----------------------------------------------------------------------------
// wkbp_ring_checker
// Watches both stream channels of the WKB polygon parser, predicts the result
// of every accepted byte and compares each accepted result in order.
// ----------------------------------------------------------------------------
module wkbp_ring_checker
    import wkbp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    input  logic         i_s_axis_tready,
    input  logic [39:0]  i_s_axis_tdata,   // [7:0] data_byte, [39:8] message_length
    input  logic         i_s_axis_tlast,   // last_byte
    input  logic         i_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    input  logic [159:0] i_m_axis_tdata,   // [63:0] lng, [127:64] lat, [159:128] point_number
    input  logic [2:0]   i_m_axis_tuser,   // status
    input  logic         i_m_axis_tlast,   // final_result
    output int           o_fail_count,
    output int           o_pending,
    output int           o_results,
    output int           o_points
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    // parser image
    logic [31:0] hdr_pos;
    logic        order_le;
    logic [31:0] word_acc;
    logic [5:0]  pt_stride;
    logic [31:0] pts_total;
    logic [31:0] pts_done;
    logic [4:0]  pt_byte;
    logic [63:0] lng_acc;
    logic [63:0] lat_acc;
    logic        parse_done;

    t_result     predicted_results [$];
    int          fail_count   = 0;
    int          result_count = 0;
    int          point_count  = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_results    = 0;
        o_points     = 0;
    end

    task automatic restart_parser();
        hdr_pos    = '0;
        order_le   = 1'b0;
        word_acc   = '0;
        pt_stride  = STRIDE_BASE;
        pts_total  = '0;
        pts_done   = '0;
        pt_byte    = '0;
        lng_acc    = '0;
        lat_acc    = '0;
        parse_done = 1'b0;
    endtask

    function automatic logic [63:0] merge_double_byte(input logic [63:0] acc,
                                                      input logic [2:0] k,
                                                      input logic [7:0] b,
                                                      input logic le);
        if (le) begin
            return acc | (64'(b) << (8 * k));
        end
        return {acc[55:0], b};
    endfunction

    // One byte through the parser image; queues the result it causes, if any.
    task automatic parse_byte(input logic [7:0] b, input logic [31:0] len, input logic last);
        t_result     r;
        t_status     err;
        logic        failed;
        logic        have;
        logic [31:0] p;
        logic [1:0]  k;
        logic [63:0] need;
        r      = '{status: ST_POINT, lng: '0, lat: '0, num: '0, fin: 1'b0};
        err    = ST_POINT;
        failed = 1'b0;
        have   = 1'b0;
        p      = hdr_pos;
        if (!parse_done) begin
            if (p < 32'(HDR_BYTES)) begin
                hdr_pos = p + 32'd1;
                if (p == 32'd0) begin
                    // length check wins over the byte-order check
                    if (len < 32'(HDR_BYTES)) begin
                        failed = 1'b1;
                        err    = ST_SHORT;
                    end else if (b > 8'd1) begin
                        failed = 1'b1;
                        err    = ST_ORDER;
                    end else begin
                        order_le = (b == 8'd1);
                    end
                end else begin
                    k = 2'(p - 32'd1);
                    if (k == 2'd0) word_acc = '0;
                    if (order_le) word_acc = word_acc | (32'(b) << (8 * k));
                    else          word_acc = {word_acc[23:0], b};
                    if (k == 2'd3) begin
                        if (p == 32'(TYPE_END)) begin
                            if (word_acc % DIM_DIVISOR != POLY_CODE) begin
                                failed = 1'b1;
                                err    = ST_NOTPOLY;
                            end else begin
                                case (word_acc / DIM_DIVISOR)
                                    1, 2:    pt_stride = STRIDE_ONE;
                                    3:       pt_stride = STRIDE_TWO;
                                    default: pt_stride = STRIDE_BASE;
                                endcase
                            end
                        end else if (p == 32'(RINGS_END)) begin
                            if (word_acc == '0) begin
                                failed = 1'b1;
                                err    = ST_NORINGS;
                            end
                        end else begin
                            // point count of the first ring
                            need = 64'(HDR_BYTES) + 64'(word_acc) * 64'(pt_stride);
                            if (need > 64'(len)) begin
                                failed = 1'b1;
                                err    = ST_OVERRUN;
                            end else if (word_acc == '0) begin
                                parse_done = 1'b1;
                                r.status   = ST_EMPTY;
                                r.fin      = 1'b1;
                                have       = 1'b1;
                            end else begin
                                pts_total = word_acc;
                                pts_done  = '0;
                                pt_byte   = '0;
                                lng_acc   = '0;
                                lat_acc   = '0;
                            end
                        end
                    end
                end
            end else begin
                // point body: lng, lat, then any Z/M words skipped
                if (pt_byte < 5'd8) begin
                    lng_acc = merge_double_byte(lng_acc, pt_byte[2:0], b, order_le);
                end else if (pt_byte < 5'd16) begin
                    lat_acc = merge_double_byte(lat_acc, pt_byte[2:0], b, order_le);
                end
                if (int'(pt_byte) + 1 >= int'(pt_stride)) begin
                    r.lng    = lng_acc;
                    r.lat    = lat_acc;
                    r.num    = pts_done;
                    r.fin    = (pts_done + 32'd1 == pts_total);
                    have     = 1'b1;
                    pts_done = pts_done + 32'd1;
                    pt_byte  = '0;
                    lng_acc  = '0;
                    lat_acc  = '0;
                    if (r.fin) parse_done = 1'b1;
                end else begin
                    pt_byte = pt_byte + 5'd1;
                end
            end
        end
        if (failed) begin
            parse_done = 1'b1;
            r.status   = err;
            r.fin      = 1'b1;
            have       = 1'b1;
        end
        if (have) predicted_results.insert(predicted_results.size(), r);
        if (last) restart_parser();
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            restart_parser();
            predicted_results.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (predicted_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("error: unexpected result status %0d point %0d at %t",
                                 i_m_axis_tuser, i_m_axis_tdata[159:128], $realtime);
                end else begin
                    want = predicted_results.pop_front();
                    if (3'(want.status) !== i_m_axis_tuser ||
                        want.lng !== i_m_axis_tdata[63:0] ||
                        want.lat !== i_m_axis_tdata[127:64] ||
                        want.num !== i_m_axis_tdata[159:128] ||
                        want.fin !== i_m_axis_tlast) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("error: result %0d at %t", result_count, $realtime);
                            $display("  exp status %0d lng %h lat %h num %0d last %0d",
                                     want.status, want.lng, want.lat, want.num, want.fin);
                            $display("  got status %0d lng %h lat %h num %0d last %0d",
                                     i_m_axis_tuser, i_m_axis_tdata[63:0],
                                     i_m_axis_tdata[127:64], i_m_axis_tdata[159:128],
                                     i_m_axis_tlast);
                        end
                    end
                    result_count++;
                    if (want.status == ST_POINT) point_count++;
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                parse_byte(i_s_axis_tdata[7:0], i_s_axis_tdata[39:8], i_s_axis_tlast);
        end
        o_fail_count <= fail_count;
        o_pending    <= predicted_results.size();
        o_results    <= result_count;
        o_points     <= point_count;
    end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives WKB polygon messages byte by byte into the ring parser, with random
// idling on both sides and one long output hold-off; the checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TARGET_BYTES   = 1400;
    localparam int CALM_FROM      = 1200;     // no idling beyond this byte count
    localparam int HOLD_AT        = 400;      // byte count that triggers the long hold-off
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 16;       // generous drain margin
    localparam int TIMEOUT_CYCLES = 400000;

    logic         i_clk   = 1'b0;
    logic         i_rst_n = 1'b0;

    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [39:0]  s_tdata  = '0;              // [7:0] data_byte, [39:8] message_length
    logic         s_tlast  = 1'b0;            // last_byte
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;                    // [63:0] lng, [127:64] lat, [159:128] point_number
    logic [2:0]   m_tuser;                    // status
    logic         m_tlast;                    // final_result

    int           fail_count;
    int           pending;
    int           result_count;
    int           point_count;

    int           bytes_sent    = 0;
    int           message_count = 0;
    int           cycle_count   = 0;
    logic         held_off      = 1'b0;

    logic [7:0]   msg [$];                    // bytes of the message being built

    always #1 i_clk = ~i_clk;

    wkb_polygon_ring_parser_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    wkbp_ring_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .i_m_axis_tlast  (m_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_results       (result_count),
        .o_points        (point_count)
    );

    // Watchdog: any hang or lost result ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("status: fail");
            $finish;
        end
    end

    // Appends one byte to the message being built.
    task automatic append_byte(input logic [7:0] b);
        msg.insert(msg.size(), b);
    endtask

    // Header: order byte, then type, ring count and point count in that order.
    task automatic make_header(input logic [7:0] order_byte, input logic [31:0] type_word,
                               input logic [31:0] rings, input logic [31:0] count);
        logic [31:0] words [3];
        logic        le;
        words = '{type_word, rings, count};
        le    = (order_byte == 8'd1);
        msg.delete();
        append_byte(order_byte);
        foreach (words[w])
            for (int j = 0; j < 4; j++)
                append_byte(le ? words[w][8*j +: 8] : words[w][8*(3-j) +: 8]);
    endtask

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++) append_byte(8'($urandom_range(0, 255)));
    endtask

    // Sends msg as one message; tlast on its final byte. Each byte waits for
    // its transaction; idle bursts are sprinkled in unless the message is sent steady or the run is calm.
    task automatic send_message(input logic [31:0] len);
        logic steady;
        steady = (bytes_sent >= CALM_FROM) || ($urandom_range(0, 3) == 0);
        for (int i = 0; i < msg.size(); i++) begin
            if (!steady && bytes_sent < CALM_FROM && $urandom_range(0, 5) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {len, msg[i]};
            s_tlast  <= (i == msg.size() - 1);
            do @(posedge i_clk); while (!s_tready);
            bytes_sent++;
        end
        message_count++;
    endtask

    // Mostly well-formed polygons with random content; the rest broken
    // headers, wrong lengths, early ends and plain noise.
    task automatic random_message();
        int          sel;
        int          dim_pick;
        int          stride;
        int          body;
        int          cut;
        logic [7:0]  order_byte;
        logic [31:0] dim;
        logic [31:0] type_word;
        logic [31:0] rings;
        logic [31:0] count;
        logic [31:0] len;
        sel        = $urandom_range(0, 99);
        order_byte = 8'($urandom_range(0, 1));
        dim_pick   = $urandom_range(0, 5);
        dim        = (dim_pick == 4) ? 32'($urandom_range(4, 4294966)) :
                     (dim_pick == 5) ? 32'd0 : 32'(dim_pick);
        stride     = (dim == 1 || dim == 2) ? 24 : (dim == 3) ? 32 : 16;
        type_word  = dim * 32'd1000 + 32'd3;
        rings      = ($urandom_range(0, 7) == 0) ? ($urandom | 32'd1) :
                     32'($urandom_range(1, 3));
        count      = 32'($urandom_range(0, 3));
        body       = int'(count) * stride +
                     (($urandom_range(0, 2) == 0) ? $urandom_range(1, 24) : 0);
        len        = 32'(13 + int'(count) * stride + $urandom_range(0, 8));
        if ($urandom_range(0, 5) == 0) len = $urandom | 32'h8000_0000;
        cut        = 0;
        if (sel < 70) begin
            // well-formed
        end else if (sel < 75) begin
            order_byte = 8'($urandom_range(2, 255));
        end else if (sel < 80) begin
            type_word = $urandom;
        end else if (sel < 84) begin
            rings = '0;
        end else if (sel < 88) begin
            if ($urandom_range(0, 1) == 0) begin
                count = $urandom | 32'h0100_0000;
                len   = 32'($urandom_range(13, 4000));
            end else begin
                count = 32'($urandom_range(1, 3));
                len   = 32'(13 + int'(count) * stride - $urandom_range(1, stride));
            end
            body = 40;
        end else if (sel < 92) begin
            len = 32'($urandom_range(0, 12));
        end else if (sel < 97) begin
            cut = 1;
        end
        if (sel >= 97) begin
            msg.delete();
            push_random($urandom_range(1, 40));
            len = $urandom;
        end else begin
            make_header(order_byte, type_word, rings, count);
            push_random(body);
            if (cut != 0) begin
                cut = $urandom_range(1, msg.size() - 1);
                msg = msg[0:cut-1];
            end
        end
        send_message(len);
    endtask

    // Output side: random stall bursts, one long hold-off so the block fills
    // and stalls its input, and always ready once the run is calm.
    initial begin
        wait (i_rst_n);
        forever begin
            if (!held_off && bytes_sent >= HOLD_AT) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (bytes_sent < CALM_FROM && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
                repeat ((bytes_sent >= CALM_FROM) ? 1 : $urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // too short: length wins even with a bad order byte, and at length zero
        msg = '{8'hFF};
        send_message(32'd12);
        msg = '{8'h01};
        send_message(32'd0);
        // bad byte order
        msg = '{8'h02};
        send_message(32'd13);
        // not a polygon: type word is a point; message ends on the error byte
        make_header(8'd1, 32'd1, 32'd1, 32'd1);
        msg = msg[0:4];
        send_message(32'd13);
        // no rings, big-endian
        make_header(8'd0, 32'd3, 32'd0, 32'd5);
        msg = msg[0:8];
        send_message(32'd13);
        // point count one byte beyond the length
        make_header(8'd1, 32'd3, 32'd1, 32'd1);
        send_message(32'd28);
        // empty first ring, then a later ring's bytes that must be swallowed
        make_header(8'd0, 32'd3, 32'd2, 32'd0);
        push_random(6);
        send_message(32'd13);
        // single point with all-ones longitude and all-zero latitude, max length
        make_header(8'd1, 32'd3, 32'd1, 32'd1);
        for (int i = 0; i < 8; i++) append_byte(8'hFF);
        for (int i = 0; i < 8; i++) append_byte(8'h00);
        send_message(32'hFFFF_FFFF);

        while (bytes_sent < TARGET_BYTES) random_message();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d bytes in %0d messages, %0d results checked, %0d of them points",
                 bytes_sent, message_count, result_count, point_count);
        $display("summary: all status codes, both byte orders, Z/M strides and early ends");
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d results outstanding", fail_count, pending);
            $display("status: fail");
        end
        $finish;
    end

endmodule
